// File: rtl/imu_pkg.sv
package imu_pkg;

    // Frame layout.
    localparam int PAYLOAD_BYTES = 8;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int WORD_COUNT    = 4;

    // Depth of the frame queue between the parser and the scaler.
    localparam int QUEUE_DEPTH = 2;

    // Protocol bytes.
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FS  = 2'd1;
    localparam int ACCEL_FS_W = 5;
    localparam int RATE_FS_W  = 11;
    localparam logic [ACCEL_FS_W-1:0] ACCEL_FS_RESET = 5'd16;
    localparam logic [RATE_FS_W-1:0]  RATE_FS_RESET  = 11'd2000;

    // Scaling.
    localparam int SCALE_W = 12;
    localparam logic [SCALE_W-1:0] ANGLE_SCALE = 12'd360;
    localparam int VALUE_W = 28;
    localparam int TEMP_W  = 25;

    // Temperature: round(|raw| * 16384 / 85) by a reciprocal multiply.
    // The reciprocal is exact for every dividend below 2^30.
    localparam int TEMP_PROD_W = 62;
    localparam int TEMP_SHIFT  = 38;
    localparam int TQ_W        = 23;
    localparam logic [31:0] TEMP_RECIP = 32'd3233857729;
    localparam logic [13:0] TEMP_ROUND = 14'd42;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 25'sd2375680;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // One parsed frame: kind and the raw little-endian words.
    typedef struct packed {
        t_kind                        kind;
        logic [WORD_COUNT-1:0][15:0]  words;
    } t_frame;

endpackage

// File: rtl/imu_front.sv
module imu_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_in_stall,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output imu_pkg::t_frame      o_frame
);

    imu_pkg::t_phase                 r_phase, n_phase;
    imu_pkg::t_kind                  r_kind,  n_kind;
    logic [imu_pkg::CNT_W-1:0]       r_count, n_count;
    logic [7:0]                      r_store [imu_pkg::PAYLOAD_BYTES];

    logic accept;
    logic collecting;
    logic store_we;

    // A byte is held off only while the queue has no room for a frame.
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign collecting = (r_count < imu_pkg::CNT_W'(imu_pkg::PAYLOAD_BYTES));

    // Next-state logic of the frame parser.
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_count = r_count;
        if (accept) begin
            case (r_phase)
                imu_pkg::PH_TYPE: begin
                    case (i_rx_byte)
                        imu_pkg::TYPE_ACCEL: begin
                            n_phase = imu_pkg::PH_DATA;
                            n_kind  = imu_pkg::KIND_ACCEL;
                            n_count = '0;
                        end
                        imu_pkg::TYPE_RATE: begin
                            n_phase = imu_pkg::PH_DATA;
                            n_kind  = imu_pkg::KIND_RATE;
                            n_count = '0;
                        end
                        imu_pkg::TYPE_ANGLE: begin
                            n_phase = imu_pkg::PH_DATA;
                            n_kind  = imu_pkg::KIND_ANGLE;
                            n_count = '0;
                        end
                        default: begin
                            n_phase = imu_pkg::PH_TYPE;
                        end
                    endcase
                end
                imu_pkg::PH_DATA: begin
                    if (collecting) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_phase = imu_pkg::PH_HUNT;
                        n_count = '0;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == imu_pkg::HDR_BYTE) ? imu_pkg::PH_TYPE
                                                               : imu_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Output decode: store a payload byte, or hand the frame over on the trailing byte.
    always_comb begin
        store_we = 1'b0;
        o_push   = 1'b0;
        case (r_phase)
            imu_pkg::PH_DATA: begin
                store_we = accept && collecting;
                o_push   = accept && !collecting;
            end
            default: begin
                store_we = 1'b0;
                o_push   = 1'b0;
            end
        endcase
    end

    // Words are little endian in the payload.
    always_comb begin
        o_frame.kind = r_kind;
        for (int w = 0; w < imu_pkg::WORD_COUNT; w++) begin
            o_frame.words[w] = {r_store[2*w+1], r_store[2*w]};
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= imu_pkg::PH_HUNT;
            r_kind  <= imu_pkg::KIND_ACCEL;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_count <= n_count;
        end
    end

    // Payload buffer, shared by all frame kinds.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count[imu_pkg::IDX_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

// File: rtl/imu_queue.sv
module imu_queue #(
    parameter int DEPTH = imu_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  imu_pkg::t_frame  i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output imu_pkg::t_frame  o_frame
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    imu_pkg::t_frame         r_entry [DEPTH];
    logic [PTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]        r_count;
    logic                    do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// File: rtl/imu_back.sv
module imu_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [imu_pkg::ACCEL_FS_W-1:0]         i_accel_fs,
    input  logic [imu_pkg::RATE_FS_W-1:0]          i_rate_fs,
    input  logic                                   i_frame_valid,
    input  imu_pkg::t_frame                        i_frame,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [1:0]                             o_frame_kind,
    output logic signed [imu_pkg::VALUE_W-1:0]     o_value_x,
    output logic signed [imu_pkg::VALUE_W-1:0]     o_value_y,
    output logic signed [imu_pkg::VALUE_W-1:0]     o_value_z,
    output logic signed [imu_pkg::TEMP_W-1:0]      o_temperature
);

    // Stage 1: products.
    logic                                  r_s1_valid;
    imu_pkg::t_kind                        r_s1_kind;
    logic signed [imu_pkg::VALUE_W-1:0]    r_s1_x, r_s1_y, r_s1_z;
    logic [imu_pkg::TQ_W-1:0]              r_s1_tq;
    logic                                  r_s1_tneg;

    // Stage 2: output register.
    logic                                  r_out_valid;
    imu_pkg::t_kind                        r_out_kind;
    logic signed [imu_pkg::VALUE_W-1:0]    r_out_x, r_out_y, r_out_z;
    logic signed [imu_pkg::TEMP_W-1:0]     r_out_t;

    logic                                  s2_ready, s1_ready;
    logic [imu_pkg::SCALE_W-1:0]           scale;
    logic signed [imu_pkg::VALUE_W:0]      prod_x, prod_y, prod_z;
    logic [15:0]                           t_raw, t_mag;
    logic [29:0]                           t_dividend;
    logic [imu_pkg::TEMP_PROD_W-1:0]       t_prod;
    logic signed [imu_pkg::TEMP_W-1:0]     t_abs, t_signed;

    // The pipeline advances whenever the stage ahead is empty or draining.
    assign s2_ready = !r_out_valid || !i_out_stall;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_pop    = i_frame_valid && s1_ready;

    // Scale factor per frame kind.
    always_comb begin
        case (i_frame.kind)
            imu_pkg::KIND_ACCEL: scale = imu_pkg::SCALE_W'({i_accel_fs, 1'b0});
            imu_pkg::KIND_RATE:  scale = imu_pkg::SCALE_W'({i_rate_fs, 1'b0});
            default:             scale = imu_pkg::ANGLE_SCALE;
        endcase
    end

    // One multiplier per axis.
    assign prod_x = $signed(i_frame.words[0]) * $signed({1'b0, scale});
    assign prod_y = $signed(i_frame.words[1]) * $signed({1'b0, scale});
    assign prod_z = $signed(i_frame.words[2]) * $signed({1'b0, scale});

    // Temperature magnitude divided by 85 after the rounding bias is added.
    assign t_raw      = i_frame.words[3];
    assign t_mag      = t_raw[15] ? (16'd0 - t_raw) : t_raw;
    assign t_dividend = {t_mag, imu_pkg::TEMP_ROUND};
    assign t_prod     = t_dividend * imu_pkg::TEMP_RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_frame_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_kind <= i_frame.kind;
            r_s1_x    <= prod_x[imu_pkg::VALUE_W-1:0];
            r_s1_y    <= prod_y[imu_pkg::VALUE_W-1:0];
            r_s1_z    <= prod_z[imu_pkg::VALUE_W-1:0];
            r_s1_tq   <= t_prod[imu_pkg::TEMP_SHIFT+imu_pkg::TQ_W-1:imu_pkg::TEMP_SHIFT];
            r_s1_tneg <= t_raw[15];
        end
    end

    // Restore the sign and add the 36.25 degree offset.
    assign t_abs    = $signed({{(imu_pkg::TEMP_W - imu_pkg::TQ_W){1'b0}}, r_s1_tq});
    assign t_signed = r_s1_tneg ? -t_abs : t_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_out_kind <= r_s1_kind;
            r_out_x    <= r_s1_x;
            r_out_y    <= r_s1_y;
            r_out_z    <= r_s1_z;
            r_out_t    <= t_signed + imu_pkg::TEMP_OFFSET;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_kind  = r_out_kind;
    assign o_value_x     = r_out_x;
    assign o_value_y     = r_out_y;
    assign o_value_z     = r_out_z;
    assign o_temperature = r_out_t;

endmodule

// File: rtl/imu_serial_frame_parser.sv
// Parser for the 0x55-headed serial frames of an inertial sensor.
// Input channel: one received byte per beat on i_rx_byte, qualified by
// i_in_valid; the block raises o_in_stall only while its frame queue is full.
// Output channel: one beat per complete frame carrying the frame kind, three
// axis values (Q12.16) and the temperature (Q9.16), all signed; o_out_valid
// holds the beat; i_out_stall from the receiver keeps it in place until taken.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes the
// acceleration (index 0) or angular rate (index 1) full scale; o_cfg_ready is
// always high and other indexes are ignored.
// Rate: one byte per cycle is accepted while o_in_stall is low. A frame
// passes from its trailing byte through the frame queue, the multiply stage
// and the output register of the scaler before its result appears. A stalled
// receiver first fills the output register, then the multiply stage, then the
// frame queue (QUEUE_DEPTH frames) before the byte input is stalled.
// Reset: synchronous, active low; the parser returns to hunting for a
// header, the pipeline and queue empty, and the full-scale registers take
// 16 g and 2000 deg/s.
module imu_serial_frame_parser #(
    parameter int QUEUE_DEPTH = imu_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic [7:0]                             i_rx_byte,
    output logic                                   o_in_stall,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [1:0]                             o_frame_kind,
    output logic signed [imu_pkg::VALUE_W-1:0]     o_value_x,
    output logic signed [imu_pkg::VALUE_W-1:0]     o_value_y,
    output logic signed [imu_pkg::VALUE_W-1:0]     o_value_z,
    output logic signed [imu_pkg::TEMP_W-1:0]      o_temperature,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [imu_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [imu_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    logic [imu_pkg::ACCEL_FS_W-1:0]  r_accel_fs;
    logic [imu_pkg::RATE_FS_W-1:0]   r_rate_fs;

    logic             queue_full, push, pop, queue_valid;
    imu_pkg::t_frame  front_frame, queue_frame;

    // Full-scale registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fs <= imu_pkg::ACCEL_FS_RESET;
            r_rate_fs  <= imu_pkg::RATE_FS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                imu_pkg::CFG_ACCEL_FS: r_accel_fs <= i_cfg_data[imu_pkg::ACCEL_FS_W-1:0];
                imu_pkg::CFG_RATE_FS:  r_rate_fs  <= i_cfg_data[imu_pkg::RATE_FS_W-1:0];
                default: ;
            endcase
        end
    end

    // Byte parser.
    imu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .o_in_stall   (o_in_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_frame      (front_frame)
    );

    // Frame queue between parser and scaler.
    imu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_frame (queue_frame)
    );

    // Scaling pipeline and output register.
    imu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accel_fs    (r_accel_fs),
        .i_rate_fs     (r_rate_fs),
        .i_frame_valid (queue_valid),
        .i_frame       (queue_frame),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_frame_kind  (o_frame_kind),
        .o_value_x     (o_value_x),
        .o_value_y     (o_value_y),
        .o_value_z     (o_value_z),
        .o_temperature (o_temperature)
    );

endmodule
